@@ src/allt_pkg.sv @@
// Shared types, constants and sizes for the autoranging light level tracker.
// No dependencies; every other file except allt_ram refers to it by scoped names.
package allt_pkg;

	// sizes
	localparam int HISTORY_DEPTH = 96;
	localparam int SAMPLE_BITS   = 16;
	localparam int ADC_BITS      = 16;
	localparam int LEVEL_BITS    = 8;
	localparam int INTERVAL_BITS = 20;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 20;
	localparam int DIV_BITS      = 16;

	localparam int ADDR_BITS  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int COUNT_BITS = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_BITS   = COUNT_BITS + LEVEL_BITS;

	// span / 100 as (span * ceil(2^23 / 100)) >> 23, exact for any 16-bit span
	localparam int PCT_RECIP_BITS = 17;
	localparam int PCT_SHIFT      = 23;

	// constants
	localparam logic [ADC_BITS-1:0] SAMPLE_MASK = ADC_BITS'((1 << SAMPLE_BITS) - 1);
	localparam logic [INTERVAL_BITS-1:0] ELAPSED_MAX = '1;
	localparam logic [INTERVAL_BITS-1:0] RST_INTERVAL = INTERVAL_BITS'(900000);
	localparam logic [ADC_BITS-1:0] RST_ADC_HIGH = ADC_BITS'(26403);
	localparam logic [ADC_BITS-1:0] RST_ADC_LOW  = ADC_BITS'(213);
	localparam logic [ADC_BITS-1:0] RST_SLOPE    = ADC_BITS'(262);
	localparam logic [LEVEL_BITS-1:0] RST_RUN_MIN = LEVEL_BITS'(100);
	localparam logic [LEVEL_BITS-1:0] LEVEL_SAT   = '1;
	localparam logic [PCT_RECIP_BITS-1:0] PCT_RECIP = PCT_RECIP_BITS'(83887);
	localparam logic [COUNT_BITS-1:0] DEPTH_CNT   = COUNT_BITS'(HISTORY_DEPTH);
	localparam logic [COUNT_BITS-1:0] LAST_POS    = COUNT_BITS'(HISTORY_DEPTH - 1);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ADC_HIGH = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ADC_LOW  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE    = 2'd3;

	// input mode codes
	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [ADC_BITS-1:0] adc_sample;
	} in_beat_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] light_percent;
		logic [LEVEL_BITS-1:0] level_min;
		logic [LEVEL_BITS-1:0] level_max;
		logic [LEVEL_BITS-1:0] level_mean;
		logic                  history_pushed;
	} out_beat_t;

	typedef struct packed {
		logic                start;
		logic [DIV_BITS-1:0] dividend;
		logic [DIV_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

@@ src/allt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module allt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 96,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/allt_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on allt_pkg for the request/response types.
module allt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  allt_pkg::div_req_t req,
	output allt_pkg::div_rsp_t rsp
);

	localparam int W  = allt_pkg::DIV_BITS;
	localparam int CB = $clog2(W);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic [CB-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          fits;

	assign shifted = {rem_q, quo_q[W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CB'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? W'(shifted - {1'b0, dvs_q}) : shifted[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ src/autoranging_light_level_tracker_top.sv @@
// Top level of the autoranging light level tracker.
// Depends on allt_pkg, allt_ram (history ring) and allt_div (shared divider).
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one beat per event:
//   mode 1 is a one millisecond tick, mode 0 an ADC sample. A tick gives
//   no result and leaves the block idle. A sample gives exactly one result beat
//   on the output channel (out_valid / out_stall / out_data).
//   Sample steps, one sample at a time through a single shared divider:
//     control
//     + span / 100 by reciprocal multiply, if a calibration bound moved
//     + light = (high - sample) / slope, unless the slope is zero
//     + on a history push: a walk of fill_count entries of the history RAM
//       through its one read port, then the mean (sum / fill_count).
//   The result sits in an output register; a new input beat is taken while
//   that register still waits on out_stall, and the block only holds at the
//   end of the next sample until the register is free.
//   Configuration: cfg_we / cfg_index / cfg_data, written while idle. Writing
//   one of the initial bound / slope registers loads the live value at once.
//   Reset (arst_n low): bounds and slope to their defaults, timer stopped,
//   history empty. The history RAM is not cleared; only written entries are
//   ever read, tracked by the fill count.
module autoranging_light_level_tracker_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  allt_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output allt_pkg::out_beat_t                 out_data,
	input  logic                                cfg_we,
	input  logic [allt_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [allt_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int AB = allt_pkg::ADC_BITS;
	localparam int LB = allt_pkg::LEVEL_BITS;
	localparam int CB = allt_pkg::COUNT_BITS;
	localparam int DB = allt_pkg::DIV_BITS;

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SLOPE  = 3'd1;  // span / 100 by reciprocal multiply
	localparam logic [2:0] ST_LIGHT  = 3'd2;  // diff / slope in flight
	localparam logic [2:0] ST_UPDATE = 3'd3;  // running min/max, push decision
	localparam logic [2:0] ST_SCAN   = 3'd4;  // walk written history entries
	localparam logic [2:0] ST_MEAN   = 3'd5;  // sum / fill in flight
	localparam logic [2:0] ST_OUT    = 3'd6;  // load output register

	logic [2:0] state_q;

	// tracker state
	logic [AB-1:0]                          adc_high_q;
	logic [AB-1:0]                          adc_low_q;
	logic [AB-1:0]                          slope_q;
	logic [LB-1:0]                          run_min_q;
	logic [LB-1:0]                          run_max_q;
	logic [LB-1:0]                          mean_q;
	logic [CB-1:0]                          wr_pos_q;
	logic [CB-1:0]                          fill_q;
	logic [allt_pkg::INTERVAL_BITS-1:0]     elapsed_q;
	logic                                   timer_on_q;
	logic [allt_pkg::INTERVAL_BITS-1:0]     interval_q;

	// per-sample working registers
	logic [AB-1:0]               sample_q;
	logic [LB-1:0]               light_q;
	logic                        pushed_q;
	logic                        div_start_q;
	logic [DB-1:0]               div_a_q;
	logic [DB-1:0]               div_b_q;
	logic [CB-1:0]               rd_idx_q;
	logic                        rd_v_s1;
	logic [LB-1:0]               lo_q;
	logic [LB-1:0]               hi_q;
	logic [allt_pkg::SUM_BITS-1:0] sum_q;

	allt_pkg::out_beat_t out_q;
	logic                out_valid_q;

	allt_pkg::div_req_t div_req;
	allt_pkg::div_rsp_t div_rsp;

	logic          in_acc;
	logic          is_sample;
	logic [AB-1:0] smp;
	logic [AB-1:0] hi_new;
	logic [AB-1:0] lo_new;
	logic          bound_moved;
	logic [AB-1:0] span;
	logic [DB+allt_pkg::PCT_RECIP_BITS-1:0] pct_prod;
	logic [AB-1:0] slope_calc;
	logic [LB-1:0] light_sat;
	logic          push_due;
	logic          scan_issue;
	logic          out_load;
	logic          ram_we;
	logic [LB-1:0] ram_rdata;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign is_sample = (in_data.mode == allt_pkg::MODE_SAMPLE);

	// bound widening for an incoming sample
	assign smp         = in_data.adc_sample & allt_pkg::SAMPLE_MASK;
	assign hi_new      = (smp > adc_high_q) ? smp : adc_high_q;
	assign lo_new      = (smp < adc_low_q) ? smp : adc_low_q;
	assign bound_moved = (smp > adc_high_q) || (smp < adc_low_q);
	assign span        = (hi_new >= lo_new) ? AB'(hi_new - lo_new) : '0;

	// new slope from the registered span (div_a_q holds it in ST_SLOPE)
	assign pct_prod   = div_a_q * allt_pkg::PCT_RECIP;
	assign slope_calc = AB'(pct_prod >> allt_pkg::PCT_SHIFT);

	assign light_sat  = (|div_rsp.quotient[DB-1:LB]) ? allt_pkg::LEVEL_SAT
	                                                  : div_rsp.quotient[LB-1:0];
	assign push_due   = (elapsed_q >= interval_q);
	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q < fill_q);
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall);
	assign ram_we     = (state_q == ST_UPDATE) && push_due;

	assign div_req.start    = div_start_q;
	assign div_req.dividend = div_a_q;
	assign div_req.divisor  = div_b_q;

	allt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	allt_ram #(
		.WIDTH (LB),
		.DEPTH (allt_pkg::HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_pos_q[allt_pkg::ADDR_BITS-1:0]),
		.wdata (light_q),
		.raddr (rd_idx_q[allt_pkg::ADDR_BITS-1:0]),
		.rdata (ram_rdata)
	);

	// control and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			adc_high_q  <= allt_pkg::RST_ADC_HIGH;
			adc_low_q   <= allt_pkg::RST_ADC_LOW;
			slope_q     <= allt_pkg::RST_SLOPE;
			run_min_q   <= allt_pkg::RST_RUN_MIN;
			run_max_q   <= '0;
			mean_q      <= '0;
			wr_pos_q    <= '0;
			fill_q      <= '0;
			elapsed_q   <= '0;
			timer_on_q  <= 1'b0;
			interval_q  <= allt_pkg::RST_INTERVAL;
			div_start_q <= 1'b0;
			rd_idx_q    <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!is_sample) begin
							if (timer_on_q && (elapsed_q != allt_pkg::ELAPSED_MAX)) begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end else begin
							if (!timer_on_q) begin
								timer_on_q <= 1'b1;
								elapsed_q  <= '0;
							end
							adc_high_q <= hi_new;
							adc_low_q  <= lo_new;
							if (bound_moved) begin
								state_q <= ST_SLOPE;
							end else if (slope_q == '0) begin
								state_q <= ST_UPDATE;
							end else begin
								div_start_q <= 1'b1;
								state_q     <= ST_LIGHT;
							end
						end
					end
				end
				ST_SLOPE: begin
					slope_q <= slope_calc;
					if (slope_calc == '0) begin
						state_q <= ST_UPDATE;
					end else begin
						div_start_q <= 1'b1;
						state_q     <= ST_LIGHT;
					end
				end
				ST_LIGHT: begin
					if (div_rsp.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (run_min_q > light_q) run_min_q <= light_q;
					if (run_max_q < light_q) run_max_q <= light_q;
					if (push_due) begin
						elapsed_q <= '0;
						wr_pos_q  <= (wr_pos_q == allt_pkg::LAST_POS) ? '0 : wr_pos_q + 1'b1;
						if (fill_q != allt_pkg::DEPTH_CNT) begin
							fill_q <= fill_q + 1'b1;
						end
						rd_idx_q <= '0;
						rd_v_s1  <= 1'b0;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_SCAN: begin
					rd_v_s1 <= scan_issue;
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end else if (!rd_v_s1) begin
						div_start_q <= 1'b1;
						state_q     <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (div_rsp.done) begin
						run_min_q <= lo_q;
						run_max_q <= hi_q;
						mean_q    <= div_rsp.quotient[LB-1:0];
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// config writes must only arrive while idle; the block itself does not enforce this
			if (cfg_we) begin
				unique case (cfg_index)
					allt_pkg::CFG_INTERVAL:
						interval_q <= cfg_data[allt_pkg::INTERVAL_BITS-1:0];
					allt_pkg::CFG_ADC_HIGH: adc_high_q <= cfg_data[AB-1:0];
					allt_pkg::CFG_ADC_LOW:  adc_low_q  <= cfg_data[AB-1:0];
					allt_pkg::CFG_SLOPE:    slope_q    <= cfg_data[AB-1:0];
					default: ;
				endcase
			end
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && is_sample) begin
					sample_q <= smp;
					if (bound_moved) begin
						div_a_q <= DB'(span);
					end else if (slope_q == '0) begin
						light_q <= allt_pkg::LEVEL_SAT;
					end else begin
						div_a_q <= DB'(hi_new - smp);
						div_b_q <= DB'(slope_q);
					end
				end
			end
			ST_SLOPE: begin
				if (slope_calc == '0) begin
					light_q <= allt_pkg::LEVEL_SAT;
				end else begin
					// high >= sample always holds after widening
					div_a_q <= DB'(adc_high_q - sample_q);
					div_b_q <= slope_calc;
				end
			end
			ST_LIGHT: begin
				if (div_rsp.done) begin
					light_q <= light_sat;
				end
			end
			ST_UPDATE: begin
				pushed_q <= push_due;
				lo_q     <= allt_pkg::LEVEL_SAT;
				hi_q     <= '0;
				sum_q    <= '0;
			end
			ST_SCAN: begin
				if (rd_v_s1) begin
					if (ram_rdata < lo_q) lo_q <= ram_rdata;
					if (ram_rdata > hi_q) hi_q <= ram_rdata;
					sum_q <= sum_q + allt_pkg::SUM_BITS'(ram_rdata);
				end else if (!scan_issue) begin
					div_a_q <= DB'(sum_q);
					div_b_q <= DB'(fill_q);
				end
			end
			ST_MEAN: ;
			ST_OUT: begin
				if (out_load) begin
					out_q.light_percent  <= light_q;
					out_q.level_min      <= run_min_q;
					out_q.level_max      <= run_max_q;
					out_q.level_mean     <= mean_q;
					out_q.history_pushed <= pushed_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ src/allt_chk.sv @@
// Port-level checker for the light level tracker, bound to the top level.
// Depends on allt_pkg for the beat types.
module allt_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input allt_pkg::in_beat_t  in_data,
	input logic                out_valid,
	input logic                out_stall,
	input allt_pkg::out_beat_t out_data
);

	// a held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// a taken sample makes the block busy on the next cycle
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.mode == allt_pkg::MODE_SAMPLE) |=> in_stall)
		else $error("block free right after a sample");

	// a tick leaves the block free on the next cycle
	a_tick_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (in_data.mode == allt_pkg::MODE_TICK) |=> !in_stall)
		else $error("block busy after a tick");

	// after a push the levels come from history, so min <= mean <= max
	a_hist_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.history_pushed |->
			(out_data.level_min <= out_data.level_mean) &&
			(out_data.level_mean <= out_data.level_max))
		else $error("history min/mean/max out of order");

endmodule

bind autoranging_light_level_tracker_top allt_chk u_allt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
